// ----- sv/vts_pkg.sv -----
// ----------------------------------------------------------------------------
// vts_pkg: shared constants and codes for the voxel trilinear sampler
// Field widths, default parameter values, command and register codes.
// ----------------------------------------------------------------------------
package vts_pkg;

	localparam int DIM_DEF        = 32;
	localparam int COORD_FRAC_DEF = 8;

	localparam int VOXEL_W   = 16;
	localparam int COORD_W   = 16;
	localparam int IDX_W     = 8;
	localparam int SIZE_W    = 6;
	localparam int CMD_W     = 2;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE  = 2'd0,
		CMD_SAMPLE = 2'd1,
		CMD_READ   = 2'd2
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SIZE_X = 2'd0,
		REG_SIZE_Y = 2'd1,
		REG_SIZE_Z = 2'd2
	} cfg_reg_t;

endpackage

// ----- sv/vts_ram.sv -----
// ----------------------------------------------------------------------------
// vts_ram: generic simple dual-port RAM
// One write port and one read port, read data registered under read enable.
// ----------------------------------------------------------------------------
module vts_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/voxel_trilinear_sampler.sv -----
// ----------------------------------------------------------------------------
// voxel_trilinear_sampler: voxel volume store with trilinear sampling
// A sample or point read goes through decode, RAM read and the y, x, z lerps.
// Throughput: one word per cycle while the output is taken; the volume sits in
// eight banks by index parity; a sample's eight neighbours are read together.
// Reset clears the size registers and the pipeline valid bits; the voxel RAM
// is not cleared and holds nothing defined until written.
// ----------------------------------------------------------------------------
module voxel_trilinear_sampler #(
	parameter int DIM        = vts_pkg::DIM_DEF,
	parameter int COORD_FRAC = vts_pkg::COORD_FRAC_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [vts_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [vts_pkg::SIZE_W-1:0]           cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [vts_pkg::CMD_W-1:0]            command,
	input  logic signed [vts_pkg::COORD_W-1:0]   coord_x,
	input  logic signed [vts_pkg::COORD_W-1:0]   coord_y,
	input  logic signed [vts_pkg::COORD_W-1:0]   coord_z,
	input  logic signed [vts_pkg::IDX_W-1:0]     voxel_x,
	input  logic signed [vts_pkg::IDX_W-1:0]     voxel_y,
	input  logic signed [vts_pkg::IDX_W-1:0]     voxel_z,
	input  logic [vts_pkg::VOXEL_W-1:0]          voxel_value,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [vts_pkg::VOXEL_W-1:0]          sample_value
);

	import vts_pkg::*;

	localparam int IW    = (DIM > 4) ? $clog2(DIM) : 2;
	localparam int AW    = 3 * (IW - 1);
	localparam int DEPTH = 1 << AW;
	localparam int FW    = COORD_FRAC;
	localparam int WW    = COORD_W - COORD_FRAC;
	localparam int CW    = (WW + 1 > IDX_W + 1) ? WW + 1 : IDX_W + 1;
	localparam int VW    = VOXEL_W;

	typedef struct packed {
		logic [IW-1:0] lo;
		logic [IW-1:0] hi;
		logic [FW-1:0] t;
	} axis_t;

	typedef struct packed {
		logic lx;
		logic hx;
		logic ly;
		logic hy;
		logic lz;
		logic hz;
	} par_t;

	// ---------------------------------------------------------------- helpers

	function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
		if (int'(s) > DIM) begin
			return SIZE_W'(DIM);
		end
		return s;
	endfunction

	function automatic logic [IW-1:0] clamp_idx(input logic signed [CW-1:0] v,
			input logic [SIZE_W-1:0] n);
		logic [SIZE_W-1:0] nm1;
		logic [IW-1:0]     r;
		nm1 = n - 1'b1;
		if (v[CW-1]) begin
			r = '0;
		end else if (v > $signed({{(CW-SIZE_W){1'b0}}, nm1})) begin
			r = IW'(nm1);
		end else begin
			r = IW'(v);
		end
		return r;
	endfunction

	function automatic axis_t split_axis(input logic signed [COORD_W-1:0] c,
			input logic [SIZE_W-1:0] n);
		logic [FW-1:0]       f;
		logic signed [CW-1:0] w;
		logic signed [CW-1:0] wh;
		axis_t               r;
		f    = c[FW-1:0];
		w    = CW'($signed(c[COORD_W-1:FW]));
		wh   = w + $signed({{(CW-1){1'b0}}, |f});
		r.lo = clamp_idx(w, n);
		r.hi = clamp_idx(wh, n);
		r.t  = f;
		return r;
	endfunction

	function automatic axis_t point_axis(input logic signed [IDX_W-1:0] v,
			input logic [SIZE_W-1:0] n);
		axis_t r;
		r.lo = clamp_idx(CW'(v), n);
		r.hi = r.lo;
		r.t  = '0;
		return r;
	endfunction

	function automatic axis_t write_axis(input logic signed [IDX_W-1:0] v);
		axis_t r;
		r.lo = IW'(v);
		r.hi = r.lo;
		r.t  = '0;
		return r;
	endfunction

	function automatic logic in_range(input logic signed [IDX_W-1:0] v,
			input logic [SIZE_W-1:0] n);
		return !v[IDX_W-1] && ($unsigned(v) < IDX_W'(n));
	endfunction

	// a + floor((b - a) * t / 2^FW); stays between a and b
	function automatic logic [VW-1:0] lerp(input logic [VW-1:0] a,
			input logic [VW-1:0] b, input logic [FW-1:0] t);
		logic signed [VW:0]      d;
		logic signed [VW+FW+1:0] p;
		logic signed [VW+1:0]    r;
		d = $signed({1'b0, b}) - $signed({1'b0, a});
		p = d * $signed({1'b0, t});
		r = $signed({2'b00, a}) + $signed(p[VW+FW+1:FW]);
		return r[VW-1:0];
	endfunction

	// ---------------------------------------------------------- configuration

	logic [SIZE_W-1:0] size_x_q;
	logic [SIZE_W-1:0] size_y_q;
	logic [SIZE_W-1:0] size_z_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= '0;
			size_y_q <= '0;
			size_z_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_SIZE_X: size_x_q <= cfg_data;
				REG_SIZE_Y: size_y_q <= cfg_data;
				REG_SIZE_Z: size_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------ stage 1: decode, clamp

	logic              adv;
	logic              out_valid_q;
	logic [VW-1:0]     sample_q;
	logic [SIZE_W-1:0] n_x;
	logic [SIZE_W-1:0] n_y;
	logic [SIZE_W-1:0] n_z;
	logic              empty_d;
	logic              res_d;
	logic              wr_d;
	axis_t             ax_d;
	axis_t             ay_d;
	axis_t             az_d;

	// the whole pipe moves together; hold everything while the result waits
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;

	assign n_x     = eff_size(size_x_q);
	assign n_y     = eff_size(size_y_q);
	assign n_z     = eff_size(size_z_q);
	assign empty_d = (n_x == '0) || (n_y == '0) || (n_z == '0);

	always_comb begin
		res_d = 1'b0;
		wr_d  = 1'b0;
		ax_d  = write_axis(voxel_x);
		ay_d  = write_axis(voxel_y);
		az_d  = write_axis(voxel_z);
		case (cmd_t'(command))
			CMD_SAMPLE: begin
				res_d = 1'b1;
				ax_d  = split_axis(coord_x, n_x);
				ay_d  = split_axis(coord_y, n_y);
				az_d  = split_axis(coord_z, n_z);
			end
			CMD_READ: begin
				// a point read is a sample with zero fraction at the clamped index
				res_d = 1'b1;
				ax_d  = point_axis(voxel_x, n_x);
				ay_d  = point_axis(voxel_y, n_y);
				az_d  = point_axis(voxel_z, n_z);
			end
			CMD_WRITE: begin
				wr_d = in_range(voxel_x, n_x) && in_range(voxel_y, n_y) &&
					in_range(voxel_z, n_z);
			end
			default: ;
		endcase
	end

	logic          v_s1;
	logic          wr_s1;
	logic          empty_s1;
	axis_t         ax_s1;
	axis_t         ay_s1;
	axis_t         az_s1;
	logic [VW-1:0] data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			wr_s1 <= 1'b0;
		end else if (adv) begin
			v_s1  <= in_valid && res_d;
			wr_s1 <= in_valid && wr_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			empty_s1 <= empty_d;
			ax_s1    <= ax_d;
			ay_s1    <= ay_d;
			az_s1    <= az_d;
			data_s1  <= voxel_value;
		end
	end

	// ------------------------------------------- stage 2: banked voxel RAM

	logic [7:0][VW-1:0] rd_s2;
	logic [AW-1:0]      waddr;
	logic [2:0]         wbank;

	assign waddr = {az_s1.lo[IW-1:1], ay_s1.lo[IW-1:1], ax_s1.lo[IW-1:1]};
	assign wbank = {az_s1.lo[0], ay_s1.lo[0], ax_s1.lo[0]};

	for (genvar b = 0; b < 8; b++) begin : g_bank
		localparam logic PX = ((b & 1) != 0);
		localparam logic PY = ((b & 2) != 0);
		localparam logic PZ = ((b & 4) != 0);

		logic [IW-1:0] xa;
		logic [IW-1:0] ya;
		logic [IW-1:0] za;
		logic [AW-1:0] raddr;
		logic          we;

		// each bank serves the neighbour whose index has this bank's parity
		assign xa    = (ax_s1.lo[0] == PX) ? ax_s1.lo : ax_s1.hi;
		assign ya    = (ay_s1.lo[0] == PY) ? ay_s1.lo : ay_s1.hi;
		assign za    = (az_s1.lo[0] == PZ) ? az_s1.lo : az_s1.hi;
		assign raddr = {za[IW-1:1], ya[IW-1:1], xa[IW-1:1]};
		assign we    = adv && wr_s1 && (wbank == 3'(b));

		vts_ram #(
			.WIDTH(VW),
			.DEPTH(DEPTH)
		) u_ram (
			.clk  (clk),
			.we   (we),
			.waddr(waddr),
			.wdata(data_s1),
			.re   (adv && v_s1),
			.raddr(raddr),
			.rdata(rd_s2[b])
		);
	end

	logic          v_s2;
	logic          empty_s2;
	par_t          par_s2;
	logic [FW-1:0] tx_s2;
	logic [FW-1:0] ty_s2;
	logic [FW-1:0] tz_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			empty_s2  <= empty_s1;
			par_s2.lx <= ax_s1.lo[0];
			par_s2.hx <= ax_s1.hi[0];
			par_s2.ly <= ay_s1.lo[0];
			par_s2.hy <= ay_s1.hi[0];
			par_s2.lz <= az_s1.lo[0];
			par_s2.hz <= az_s1.hi[0];
			tx_s2     <= ax_s1.t;
			ty_s2     <= ay_s1.t;
			tz_s2     <= az_s1.t;
		end
	end

	// ------------------------------------------------- stage 3: lerp along y

	// corner[z][x][y], 0 = lower neighbour, 1 = upper neighbour
	logic [1:0][1:0][1:0][VW-1:0] corner;

	always_comb begin
		for (int zs = 0; zs < 2; zs++) begin
			for (int xs = 0; xs < 2; xs++) begin
				for (int ys = 0; ys < 2; ys++) begin
					corner[zs][xs][ys] = rd_s2[{
						(zs != 0) ? par_s2.hz : par_s2.lz,
						(ys != 0) ? par_s2.hy : par_s2.ly,
						(xs != 0) ? par_s2.hx : par_s2.lx}];
				end
			end
		end
	end

	logic                v_s3;
	logic                empty_s3;
	logic [FW-1:0]       tx_s3;
	logic [FW-1:0]       tz_s3;
	logic [1:0][VW-1:0]  a_s3;
	logic [1:0][VW-1:0]  b_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			empty_s3 <= empty_s2;
			tx_s3    <= tx_s2;
			tz_s3    <= tz_s2;
			for (int k = 0; k < 2; k++) begin
				a_s3[k] <= lerp(corner[k][0][0], corner[k][0][1], ty_s2);
				b_s3[k] <= lerp(corner[k][1][0], corner[k][1][1], ty_s2);
			end
		end
	end

	// ------------------------------------------------- stage 4: lerp along x

	logic               v_s4;
	logic               empty_s4;
	logic [FW-1:0]      tz_s4;
	logic [1:0][VW-1:0] s_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			empty_s4 <= empty_s3;
			tz_s4    <= tz_s3;
			for (int k = 0; k < 2; k++) begin
				s_s4[k] <= lerp(a_s3[k], b_s3[k], tx_s3);
			end
		end
	end

	// ------------------------------------- stage 5: lerp along z, output word

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// an empty volume answers zero
			sample_q <= empty_s4 ? '0 : lerp(s_s4[0], s_s4[1], tz_s4);
		end
	end

	assign out_valid    = out_valid_q;
	assign sample_value = sample_q;

endmodule
